// ===== rtl/core/bbf_pkg.sv =====
// bbf_pkg: shared widths, register indexes and request codes for the
// plus-shaped bilateral block filter. No dependencies.
package bbf_pkg;

    // fixed field widths of the channels
    localparam int REQ_W      = 1;
    localparam int TADDR_W    = 10;
    localparam int WT_W       = 16;
    localparam int PIX_IO_W   = 10;
    localparam int XY_W       = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // register widths
    localparam int DIM_W   = 8;
    localparam int CW_W    = 17;
    localparam int MAXD_W  = 10;
    localparam int SHIFT_W = 2;

    // weight sum: center weight plus four shifted neighbor weights
    localparam int DEN_W = 19;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_WT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WT_SHIFT     = 3'd4;

    // request codes
    localparam logic REQ_TABLE = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

endpackage

// ===== rtl/core/bbf_ifs.sv =====
// bbf_ifs: valid/ready channel interfaces for input beats, result beats and
// register writes. Depends on bbf_pkg.
interface bbf_in_if;
    import bbf_pkg::*;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [TADDR_W-1:0]  table_addr;
    logic [WT_W-1:0]     table_weight;
    logic [PIX_IO_W-1:0] pixel;
    modport source (output valid, req_type, table_addr, table_weight, pixel, input ready);
    modport sink   (input valid, req_type, table_addr, table_weight, pixel, output ready);
endinterface

interface bbf_out_if;
    import bbf_pkg::*;
    logic                valid;
    logic                ready;
    logic [PIX_IO_W-1:0] filtered_pixel;
    logic [XY_W-1:0]     out_x;
    logic [XY_W-1:0]     out_y;
    logic                last_of_run;
    logic                block_done;
    modport source (output valid, filtered_pixel, out_x, out_y, last_of_run, block_done,
                    input ready);
    modport sink   (input valid, filtered_pixel, out_x, out_y, last_of_run, block_done,
                    output ready);
endinterface

interface bbf_cfg_if;
    import bbf_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bbf_div.sv =====
// bbf_div: restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module bbf_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_sh;

    // shift in the next numerator bit
    assign n_sh = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (n_sh >= {1'b0, r_den}) begin
                r_rem <= n_sh - {1'b0, r_den};
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_sh;
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== rtl/core/plus_bilateral_block_filter.sv =====
// Plus-shaped bilateral block filter: pixels arrive in raster order and each
// pixel beat releases zero to three filtered results. One item is worked at a
// time. For a pixel beat, per result, the center tap is read through the row
// memory and each existing neighbor through the row memory and then the weight
// memory, one tap at a time, with missing neighbors skipped; a setup step and
// the quotient divider follow (one bit a cycle, skipped on a zero weight sum),
// then the output handshake, which waits while the result side stalls. Last
// the pixel is stored in the row memory.
// Results for row y-1 come out as row y arrives, the last row also yields its
// left neighbor, and the bottom right pixel yields itself with block_done set.
// Writing block_width or block_height restarts the block at the top left. No
// clearing pass after reset.
module plus_bilateral_block_filter #(
    parameter int MAX_WIDTH   = 128,
    parameter int MAX_HEIGHT  = 128,
    parameter int TABLE_DEPTH = 1024,
    parameter int PIXEL_BITS  = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bbf_in_if.sink        i_in,
    bbf_out_if.source     o_out,
    bbf_cfg_if.sink       i_cfg
);
    import bbf_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WDW   = $clog2(MAX_WIDTH + 1);
    localparam int HDW   = $clog2(MAX_HEIGHT + 1);
    localparam int RAW   = $clog2(2 * MAX_WIDTH);
    localparam int TW    = $clog2(TABLE_DEPTH);
    localparam int PW    = PIXEL_BITS;
    localparam int NS_W  = PW + WT_W + 2;
    localparam int WS_W  = WT_W + 2;
    localparam int CP_W  = PW + CW_W;
    localparam int NUM_W = PW + 20;
    localparam logic [NUM_W-1:0] PIX_MAX = NUM_W'((1 << PW) - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRD   = 3'd1;
    localparam logic [2:0] S_TPX   = 3'd2;
    localparam logic [2:0] S_TAC   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_STORE = 3'd7;

    // registers
    logic [2:0]          r_state;
    logic [DIM_W-1:0]    r_bw, r_bh;
    logic [CW_W-1:0]     r_cw;
    logic [MAXD_W-1:0]   r_maxd;
    logic [SHIFT_W-1:0]  r_sh;
    logic [XW-1:0]       r_col, r_cx;
    logic [YW-1:0]       r_row, r_cy;
    logic [PW-1:0]       r_cpix, r_c, r_n;
    logic [2:0]          r_rm;
    logic [1:0]          r_ri;
    logic [2:0]          r_tap;
    logic [CP_W-1:0]     r_cprod;
    logic [NS_W-1:0]     r_nsum;
    logic [WS_W-1:0]     r_wsum;
    logic [PIX_IO_W-1:0] r_fp;
    logic [XY_W-1:0]     r_ox, r_oy;
    logic                r_last, r_done;

    // memories
    logic [PW-1:0]   m_row [2*MAX_WIDTH];
    logic [WT_W-1:0] m_wt  [TABLE_DEPTH];
    logic [PW-1:0]   r_row_q;
    logic [WT_W-1:0] r_wt_q;

    // combinational
    logic [WDW-1:0]   eff_w;
    logic [HDW-1:0]   eff_h;
    logic [XW-1:0]    ra, tx;
    logic [YW-1:0]    rb, ty;
    logic             tap_ex, tap_cur;
    logic [PW-1:0]    tap_val, dv;
    logic [31:0]      lim32, idx32;
    logic [TW-1:0]    wt_idx;
    logic [RAW-1:0]   rd_addr, wr_addr;
    logic [NUM_W-1:0] s_val, div_num, div_q;
    logic [DEN_W-1:0] t_val;
    logic             div_start, div_done;
    logic             in_beat, cfg_beat, out_beat;
    logic [XW-1:0]    start_x;
    logic [YW-1:0]    start_y;
    logic [2:0]       start_rm;
    logic             res_last;

    assign in_beat  = i_in.valid && i_in.ready;
    assign cfg_beat = i_cfg.valid && i_cfg.ready;
    assign out_beat = o_out.valid && o_out.ready;

    // effective block size
    always_comb begin
        if (r_bw < DIM_W'(2)) begin
            eff_w = WDW'(2);
        end else if (32'(r_bw) > MAX_WIDTH) begin
            eff_w = WDW'(MAX_WIDTH);
        end else begin
            eff_w = WDW'(r_bw);
        end
        if (r_bh < DIM_W'(2)) begin
            eff_h = HDW'(2);
        end else if (32'(r_bh) > MAX_HEIGHT) begin
            eff_h = HDW'(MAX_HEIGHT);
        end else begin
            eff_h = HDW'(r_bh);
        end
    end

    // position of the next pixel, restarted if it lies outside the block
    always_comb begin
        if (32'(r_col) >= 32'(eff_w) || 32'(r_row) >= 32'(eff_h)) begin
            start_x = '0;
            start_y = '0;
        end else begin
            start_x = r_col;
            start_y = r_row;
        end
        start_rm[0] = (start_y != '0);
        start_rm[1] = (32'(start_y) + 1 == 32'(eff_h)) && (start_x != '0);
        start_rm[2] = (32'(start_y) + 1 == 32'(eff_h)) && (32'(start_x) + 1 == 32'(eff_w));
    end

    // position of the result being worked
    always_comb begin
        case (r_ri)
            2'd0: begin
                ra = r_cx;
                rb = r_cy - 1'b1;
            end
            2'd1: begin
                ra = r_cx - 1'b1;
                rb = r_cy;
            end
            default: begin
                ra = r_cx;
                rb = r_cy;
            end
        endcase
        case (r_ri)
            2'd0:    res_last = !r_rm[1] && !r_rm[2];
            2'd1:    res_last = !r_rm[2];
            default: res_last = 1'b1;
        endcase
    end

    // tap position and presence
    always_comb begin
        tx     = ra;
        ty     = rb;
        tap_ex = 1'b0;
        case (r_tap)
            3'd0: tap_ex = 1'b1;
            3'd1: begin
                tx     = ra - 1'b1;
                tap_ex = (ra != '0);
            end
            3'd2: begin
                tx     = ra + 1'b1;
                tap_ex = (32'(ra) + 1 < 32'(eff_w));
            end
            3'd3: begin
                ty     = rb - 1'b1;
                tap_ex = (rb != '0);
            end
            3'd4: begin
                ty     = rb + 1'b1;
                tap_ex = (32'(rb) + 1 < 32'(eff_h));
            end
            default: tap_ex = 1'b0;
        endcase
        tap_cur = (tx == r_cx) && (ty == r_cy);
        tap_val = tap_cur ? r_cpix : r_row_q;
        rd_addr = ty[0] ? RAW'(MAX_WIDTH) + RAW'(tx) : RAW'(tx);
        wr_addr = r_cy[0] ? RAW'(MAX_WIDTH) + RAW'(r_cx) : RAW'(r_cx);
    end

    // clamped weight table index
    always_comb begin
        dv     = (tap_val >= r_c) ? tap_val - r_c : r_c - tap_val;
        lim32  = (32'(r_maxd) < TABLE_DEPTH - 1) ? 32'(r_maxd) : 32'(TABLE_DEPTH - 1);
        idx32  = (32'(dv) > lim32) ? lim32 : 32'(dv);
        wt_idx = TW'(idx32);
    end

    // row memory: read every cycle, write the current pixel at the end
    always_ff @(posedge i_clk) begin
        r_row_q <= m_row[rd_addr];
        if (r_state == S_STORE) begin
            m_row[wr_addr] <= r_cpix;
        end
    end

    // weight table
    always_ff @(posedge i_clk) begin
        r_wt_q <= m_wt[wt_idx];
        if (in_beat && i_in.req_type == REQ_TABLE && 32'(i_in.table_addr) < TABLE_DEPTH) begin
            m_wt[TW'(i_in.table_addr)] <= i_in.table_weight;
        end
    end

    // numerator and denominator
    always_comb begin
        s_val   = NUM_W'(r_cprod) + NUM_W'(r_nsum >> r_sh);
        t_val   = DEN_W'(r_cw) + DEN_W'(r_wsum >> r_sh);
        div_num = s_val + NUM_W'(t_val >> 1);
        div_start = (r_state == S_FIN) && (t_val != '0);
    end

    bbf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (t_val),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // sequencer and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bw    <= DIM_W'(4);
            r_bh    <= DIM_W'(4);
            r_cw    <= CW_W'(65535);
            r_maxd  <= MAXD_W'(1023);
            r_sh    <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_beat && i_in.req_type == REQ_PIXEL) begin
                        r_cx   <= start_x;
                        r_cy   <= start_y;
                        r_cpix <= PW'(32'(i_in.pixel));
                        r_rm   <= start_rm;
                        r_tap  <= '0;
                        r_nsum <= '0;
                        r_wsum <= '0;
                        if (start_rm[0]) begin
                            r_ri    <= 2'd0;
                            r_state <= S_TRD;
                        end else if (start_rm[1]) begin
                            r_ri    <= 2'd1;
                            r_state <= S_TRD;
                        end else if (start_rm[2]) begin
                            r_ri    <= 2'd2;
                            r_state <= S_TRD;
                        end else begin
                            r_state <= S_STORE;
                        end
                    end
                end
                // issue the row read for a present tap, skip absent ones
                S_TRD: begin
                    if (tap_ex) begin
                        r_state <= S_TPX;
                    end else if (r_tap == 3'd4) begin
                        r_state <= S_FIN;
                    end else begin
                        r_tap <= r_tap + 1'b1;
                    end
                end
                // pixel value ready: center product or weight lookup
                S_TPX: begin
                    if (r_tap == 3'd0) begin
                        r_c     <= tap_val;
                        r_cprod <= CP_W'(tap_val) * CP_W'(r_cw);
                        r_tap   <= r_tap + 1'b1;
                        r_state <= S_TRD;
                    end else begin
                        r_n     <= tap_val;
                        r_state <= S_TAC;
                    end
                end
                // weight ready: accumulate
                S_TAC: begin
                    r_nsum <= r_nsum + NS_W'(NS_W'(r_n) * NS_W'(r_wt_q));
                    r_wsum <= r_wsum + WS_W'(r_wt_q);
                    if (r_tap == 3'd4) begin
                        r_state <= S_FIN;
                    end else begin
                        r_tap   <= r_tap + 1'b1;
                        r_state <= S_TRD;
                    end
                end
                S_FIN: begin
                    r_ox   <= XY_W'(32'(ra));
                    r_oy   <= XY_W'(32'(rb));
                    r_last <= res_last;
                    r_done <= (r_ri == 2'd2);
                    if (t_val == '0) begin
                        r_fp    <= PIX_IO_W'(r_c);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_fp    <= (div_q > PIX_MAX) ? PIX_IO_W'(PIX_MAX) : PIX_IO_W'(div_q);
                        r_state <= S_OUT;
                    end
                end
                // hold the result beat, then next result or store
                S_OUT: begin
                    if (out_beat) begin
                        r_tap  <= '0;
                        r_nsum <= '0;
                        r_wsum <= '0;
                        if (r_ri == 2'd0 && r_rm[1]) begin
                            r_ri    <= 2'd1;
                            r_state <= S_TRD;
                        end else if (r_ri != 2'd2 && r_rm[2]) begin
                            r_ri    <= 2'd2;
                            r_state <= S_TRD;
                        end else begin
                            r_state <= S_STORE;
                        end
                    end
                end
                // advance the raster position
                S_STORE: begin
                    if (32'(r_cx) + 1 >= 32'(eff_w)) begin
                        r_col <= '0;
                        if (32'(r_cy) + 1 >= 32'(eff_h)) begin
                            r_row <= '0;
                        end else begin
                            r_row <= r_cy + 1'b1;
                        end
                    end else begin
                        r_col <= r_cx + 1'b1;
                        r_row <= r_cy;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            // register writes
            if (cfg_beat) begin
                case (i_cfg.index)
                    REG_BLOCK_WIDTH: begin
                        r_bw  <= i_cfg.data[DIM_W-1:0];
                        r_col <= '0;
                        r_row <= '0;
                    end
                    REG_BLOCK_HEIGHT: begin
                        r_bh  <= i_cfg.data[DIM_W-1:0];
                        r_col <= '0;
                        r_row <= '0;
                    end
                    REG_CENTER_WT: r_cw   <= i_cfg.data[CW_W-1:0];
                    REG_MAX_DIFF:  r_maxd <= i_cfg.data[MAXD_W-1:0];
                    REG_WT_SHIFT:  r_sh   <= i_cfg.data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ports
    assign i_in.ready           = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = (r_state == S_OUT);
    assign o_out.filtered_pixel = r_fp;
    assign o_out.out_x          = r_ox;
    assign o_out.out_y          = r_oy;
    assign o_out.last_of_run    = r_last;
    assign o_out.block_done     = r_done;

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("input taken while a result is pending");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide step");

    a_pos_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_col) < 32'(eff_w)))
        else $error("raster column outside the block");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.block_done) |-> o_out.last_of_run)
        else $error("bottom right result not last of its run");
endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for plus_bilateral_block_filter, with a
// scoreboard that predicts every filtered pixel from the accepted beats.
// Depends on bbf_pkg, the bbf_*_if interfaces and the filter rtl.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bbf_pkg::*;

    localparam int NUM_COLS   = 128;
    localparam int NUM_ROWS   = 128;
    localparam int WT_ENTRIES = 1024;
    localparam int TBL_FILL   = 8;
    localparam int PIX_MAX    = 1023;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 150;
    localparam int ITEM_GOAL  = 210;

    typedef struct packed {
        logic [PIX_IO_W-1:0] value;
        logic [XY_W-1:0]     x;
        logic [XY_W-1:0]     y;
        logic                last;
        logic                done;
    } t_filt_res;

    // expected filtered pixels, computed from the accepted beats
    class bbf_scoreboard;
        bit [WT_W-1:0]     wtab[WT_ENTRIES];
        bit [PIX_IO_W-1:0] rows[2*NUM_COLS];
        int unsigned col, row, bw, bh, cw, maxd, sh;
        int unsigned cx, cy, cpix, ew, eh;
        t_filt_res   pend_q[$];
        int          errors, n_checked, n_pixels, n_inputs;

        function new();
            col = 0; row = 0; bw = 4; bh = 4; cw = 65535; maxd = 1023; sh = 0;
            errors = 0; n_checked = 0; n_pixels = 0; n_inputs = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, int unsigned val);
            case (idx)
                REG_BLOCK_WIDTH: begin
                    bw = val & 8'hFF; col = 0; row = 0;
                end
                REG_BLOCK_HEIGHT: begin
                    bh = val & 8'hFF; col = 0; row = 0;
                end
                REG_CENTER_WT: cw = val & 17'h1FFFF;
                REG_MAX_DIFF:  maxd = val & 10'h3FF;
                REG_WT_SHIFT:  sh = val & 2'h3;
                default: ;
            endcase
        endfunction

        function int unsigned dim_sat(int unsigned v, int unsigned hi);
            if (v < 2) return 2;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned pix(int unsigned a, int unsigned b);
            if (a == cx && b == cy) return cpix;
            return rows[(b & 1) * NUM_COLS + a];
        endfunction

        function int unsigned wt(int unsigned n, int unsigned c);
            int unsigned d;
            d = (n > c) ? n - c : c - n;
            if (d > maxd) d = maxd;
            if (d > WT_ENTRIES - 1) d = WT_ENTRIES - 1;
            return wtab[d];
        endfunction

        function int unsigned filt(int unsigned a, int unsigned b);
            longint unsigned nsum, wsum, s, t, r;
            int unsigned c, n, w;
            c = pix(a, b);
            nsum = 0; wsum = 0;
            // left, right, up, down taps where they exist
            if (a > 0) begin
                n = pix(a - 1, b); w = wt(n, c); nsum += n * w; wsum += w;
            end
            if (a + 1 < ew) begin
                n = pix(a + 1, b); w = wt(n, c); nsum += n * w; wsum += w;
            end
            if (b > 0) begin
                n = pix(a, b - 1); w = wt(n, c); nsum += n * w; wsum += w;
            end
            if (b + 1 < eh) begin
                n = pix(a, b + 1); w = wt(n, c); nsum += n * w; wsum += w;
            end
            s = longint'(c) * cw + (nsum >> sh);
            t = cw + (wsum >> sh);
            if (t == 0) return c;
            r = (s + (t >> 1)) / t;
            if (r > PIX_MAX) r = PIX_MAX;
            return 32'(r);
        endfunction

        function void push(int unsigned a, int unsigned b, bit done);
            t_filt_res e;
            e.value = PIX_IO_W'(filt(a, b));
            e.x = XY_W'(a); e.y = XY_W'(b); e.last = 1'b0; e.done = done;
            pend_q.push_back(e);
        endfunction

        // accepted input beat
        function void note_input(logic req, int unsigned addr, int unsigned wv,
                                 int unsigned pv);
            int unsigned k;
            n_inputs++;
            if (req == REQ_TABLE) begin
                wtab[addr] = WT_W'(wv);
                return;
            end
            n_pixels++;
            ew = dim_sat(bw, NUM_COLS);
            eh = dim_sat(bh, NUM_ROWS);
            if (col >= ew || row >= eh) begin
                col = 0; row = 0;
            end
            cx = col; cy = row; cpix = pv;
            k = pend_q.size();
            if (cy > 0) push(cx, cy - 1, 1'b0);
            if (cy + 1 == eh) begin
                if (cx > 0) push(cx - 1, cy, 1'b0);
                if (cx + 1 == ew) push(cx, cy, 1'b1);
            end
            if (pend_q.size() > k) pend_q[pend_q.size()-1].last = 1'b1;
            rows[(cy & 1) * NUM_COLS + cx] = PIX_IO_W'(pv);
            col++;
            if (col >= ew) begin
                col = 0;
                row++;
                if (row >= eh) row = 0;
            end
        endfunction

        // accepted result beat
        function void check_result(t_filt_res got);
            t_filt_res e;
            n_checked++;
            if (pend_q.size() == 0) begin
                $error("unexpected result beat at x=%0d y=%0d", got.x, got.y);
                errors++;
                return;
            end
            e = pend_q.pop_front();
            if (got.value !== e.value) begin
                $error("filtered_pixel: expected %0d, got %0d", e.value, got.value);
                errors++;
            end
            if (got.x !== e.x) begin
                $error("out_x: expected %0d, got %0d", e.x, got.x);
                errors++;
            end
            if (got.y !== e.y) begin
                $error("out_y: expected %0d, got %0d", e.y, got.y);
                errors++;
            end
            if (got.last !== e.last) begin
                $error("last_of_run: expected %0d, got %0d", e.last, got.last);
                errors++;
            end
            if (got.done !== e.done) begin
                $error("block_done: expected %0d, got %0d", e.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bbf_in_if  in_ch();
    bbf_out_if out_ch();
    bbf_cfg_if cfg_ch();

    plus_bilateral_block_filter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    bbf_scoreboard sb;
    bit            no_gaps;
    bit            no_stall;
    int            idle_cycles;
    int            stall_left;
    int            n_phases;

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (no_stall) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            out_ch.ready <= 1'b0;
            stall_left   <= pick_gap();
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        t_filt_res got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.value = out_ch.filtered_pixel;
                got.x     = out_ch.out_x;
                got.y     = out_ch.out_y;
                got.last  = out_ch.last_of_run;
                got.done  = out_ch.block_done;
                sb.check_result(got);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("** plus_bilateral_block_filter: FAILED **");
                $finish;
            end
        end
    end

    // one input beat, with a random gap ahead of it
    task automatic send_beat(logic req, int unsigned addr, int unsigned wv, int unsigned pv);
        int g;
        g = no_gaps ? 0 : pick_gap();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.req_type     <= req;
        in_ch.table_addr   <= TADDR_W'(addr);
        in_ch.table_weight <= WT_W'(wv);
        in_ch.pixel        <= PIX_IO_W'(pv);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(req, addr, wv, pv);
    endtask

    task automatic send_pixel(int unsigned pv);
        send_beat(REQ_PIXEL, $urandom_range(0, 1023), $urandom_range(0, 65535), pv);
    endtask

    task automatic send_weight(int unsigned addr, int unsigned wv);
        send_beat(REQ_TABLE, addr, wv, $urandom_range(0, 1023));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pend_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= t_cfg_data'(val);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_phase(int unsigned w, int unsigned h, int unsigned cw,
                             int unsigned md, int unsigned sh);
        wait_drained();
        write_reg(REG_BLOCK_WIDTH, w);
        write_reg(REG_BLOCK_HEIGHT, h);
        write_reg(REG_CENTER_WT, cw);
        write_reg(REG_MAX_DIFF, md);
        write_reg(REG_WT_SHIFT, sh);
        n_phases++;
    endtask

    // pixel content: mostly smooth around a base, sometimes anything
    function automatic int unsigned rand_pix(int unsigned base);
        int v;
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1023);
        v = int'(base) + $urandom_range(0, 40) - 20;
        if (v < 0) v = 0;
        if (v > PIX_MAX) v = PIX_MAX;
        return v;
    endfunction

    task automatic run_pixels(int n, bit mix_table);
        int unsigned base;
        base = $urandom_range(0, 1023);
        for (int i = 0; i < n; i++) begin
            if (mix_table && $urandom_range(0, 9) == 0)
                send_weight($urandom_range(0, 1023), $urandom_range(0, 65535));
            send_pixel(rand_pix(base));
        end
    endtask

    initial begin
        int unsigned w, h;
        sb = new();
        no_gaps = 1'b0; no_stall = 1'b0; idle_cycles = 0; n_phases = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0; in_ch.req_type = REQ_TABLE; in_ch.table_addr = '0;
        in_ch.table_weight = '0; in_ch.pixel = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = REG_BLOCK_WIDTH; cfg_ch.data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the low table entries and the ones the extreme block reaches;
        // later phases keep max_diff_index inside the low entries
        no_gaps = 1'b1;
        for (int a = 0; a < TBL_FILL; a++)
            send_weight(a, (a == 0) ? 65535 : $urandom_range(0, 65535));
        send_weight(511, $urandom_range(0, 65535));
        send_weight(512, $urandom_range(0, 65535));
        send_weight(1023, 0);
        no_gaps = 1'b0;

        // directed: one default 4x4 block of extreme pixels
        for (int i = 0; i < 16; i++) begin
            if (i == 5) send_weight(1023, 65535);
            if (i == 9) begin
                // sender holds off until every result is back
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pend_q.size() != 0) @(posedge i_clk);
            end
            send_pixel((i % 3 == 0) ? 0 : ((i % 3 == 1) ? PIX_MAX : 512));
        end

        // smallest block, unit center weight, no clamp room, shift of two
        set_phase(2, 2, 1, 0, 2);
        run_pixels(8, 1'b0);
        // out-of-range sizes saturate to the minimum
        set_phase(0, 1, 131071, TBL_FILL - 1, 1);
        run_pixels(8, 1'b1);
        // widest block, with the width saturating from above
        set_phase(255, 2, 65535, 5, 0);
        no_stall = 1'b1;
        run_pixels(130, 1'b0);
        no_stall = 1'b0;
        // zero weight sum: center weight zero and a zero entry at index zero
        set_phase(3, 3, 0, 0, 0);
        send_weight(0, 0);
        run_pixels(9, 1'b0);
        send_weight(0, $urandom_range(1, 65535));
        // partial block cut short by a size write
        run_pixels(4, 1'b0);

        // random phases, small blocks
        while (sb.n_inputs < ITEM_GOAL) begin
            w = $urandom_range(2, 4);
            h = $urandom_range(2, 3);
            set_phase(w, h, $urandom_range(0, 3) == 0 ? $urandom_range(1, 300)
                                                     : $urandom_range(1, 131071),
                      $urandom_range(0, 1) ? TBL_FILL - 1 : $urandom_range(0, TBL_FILL - 1),
                      $urandom_range(0, 3));
            no_stall = ($urandom_range(0, 4) == 0);
            no_gaps  = ($urandom_range(0, 4) == 0);
            run_pixels(w * h + ($urandom_range(0, 3) == 0 ?
                       $urandom_range(1, w * h - 1) : 0), 1'b1);
        end
        no_stall = 1'b0;
        no_gaps  = 1'b0;

        // drain and finish
        wait_drained();
        $display("covered %0d pixel beats over %0d register settings, %0d results checked",
                 sb.n_pixels, n_phases, sb.n_checked);
        if (sb.errors == 0 && sb.pend_q.size() == 0) begin
            $display("** plus_bilateral_block_filter: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.errors,
                     sb.pend_q.size());
            $display("** plus_bilateral_block_filter: FAILED **");
        end
        $finish;
    end

endmodule
